// ===== hdl/dems_pkg.sv =====
// Package for the binary64 exponent/mantissa split block.
// Constants and helper functions; no dependencies.
`default_nettype none
package dems_pkg;
    localparam int unsigned VAL_W  = 64;
    localparam int unsigned EXP_W  = 13;
    localparam int unsigned FRAC_W = 52;
    localparam int unsigned POS_W  = 6;
    localparam logic [31:0] HI_SUBN   = 32'h0010_0000;
    localparam logic [31:0] HI_KEEP   = 32'h800f_ffff;
    localparam logic [31:0] HI_ONE    = 32'h3ff0_0000;
    localparam logic [31:0] HI_THRESH = 32'h3ff6_a09e;
    localparam logic [31:0] HI_HALF   = 32'h0010_0000;
    localparam logic signed [EXP_W-1:0] EXP_BIAS_N = -13'sd1023;
    localparam logic signed [EXP_W-1:0] EXP_BIAS_S = -13'sd1077;

    // position of the highest set bit of a 52-bit fraction (0 when zero)
    function automatic logic [POS_W-1:0] f_top52(input logic [FRAC_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < FRAC_W; i++) begin
            if (v[i]) p = POS_W'(i);
        end
        return p;
    endfunction

    // position of the highest set bit of a 12-bit magnitude
    function automatic logic [3:0] f_top12(input logic [11:0] v);
        logic [3:0] p;
        p = '0;
        for (int i = 0; i < 12; i++) begin
            if (v[i]) p = 4'(i);
        end
        return p;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/double_exponent_mantissa_split.sv =====
// Top level of the binary64 exponent/mantissa split for a log front end.
// Depends on dems_pkg.
//
// Usage: pulse start with an operand on i_value_bits; busy is never raised,
// so one item may enter every cycle. Each item gives one result on
// o_exponent_int, o_exponent_double_bits and o_mantissa_bits, marked by
// o_strobe for exactly one cycle.
// The accepting edge registers the item into stage 1; it then passes stages
// 2, 3 and 4 in order, and o_strobe is the stage-4 valid bit.
// Throughput: one item per cycle, set by the four-stage pipeline
// (normalise search, shift, exponent reduce, exponent-to-binary64 convert).
// Reset (synchronous, i_rst_n low) clears the stage valid bits; items in
// flight are dropped. The receiver cannot stall: results are shown once and
// the pipeline never holds.
`default_nettype none
module double_exponent_mantissa_split
    import dems_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [VAL_W-1:0]        i_value_bits,
    output logic                         o_strobe,
    output logic signed [EXP_W-1:0]      o_exponent_int,
    output logic [VAL_W-1:0]             o_exponent_double_bits,
    output logic [VAL_W-1:0]             o_mantissa_bits
);
    // stage 1: subnormal detect and leading-one search
    logic             r_v1, r_sub1;
    logic [VAL_W-1:0] r_u1;
    logic [POS_W-1:0] r_p1;
    // stage 2: normalised operand
    logic             r_v2, r_sub2;
    logic [VAL_W-1:0] r_u2;
    // stage 3: reduced exponent and mantissa
    logic                    r_v3;
    logic signed [EXP_W-1:0] r_e3;
    logic [VAL_W-1:0]        r_m3;
    // stage 4: output
    logic                    r_v4;
    logic signed [EXP_W-1:0] r_e4;
    logic [VAL_W-1:0]        r_d4, r_m4;

    logic [VAL_W-1:0]        n_u2;
    logic [FRAC_W-1:0]       w_f2;
    logic [31:0]             w_hi3, w_hi2b;
    logic signed [EXP_W-1:0] n_e3;
    logic [EXP_W-1:0]        w_mag;
    logic [3:0]              w_p4;
    logic [VAL_W-1:0]        n_d4;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u1   <= i_value_bits;
        r_sub1 <= i_value_bits[63:32] < HI_SUBN;
        r_p1   <= f_top52(i_value_bits[FRAC_W-1:0]);
    end

    // exact 2^54 scaling of zero/positive subnormal as a normalising shift
    always_comb begin
        w_f2 = r_u1[FRAC_W-1:0];
        n_u2 = r_u1;
        if (r_sub1 && (w_f2 != '0)) begin
            n_u2 = {1'b0, 11'(r_p1) + 11'd3, 52'(w_f2 << (6'(FRAC_W) - r_p1))};
        end
    end

    always_ff @(posedge i_clk) begin
        r_u2   <= n_u2;
        r_sub2 <= r_sub1;
    end

    always_comb begin
        w_hi3  = r_u2[63:32];
        w_hi2b = (w_hi3 & HI_KEEP) | HI_ONE;
        n_e3   = (r_sub2 ? EXP_BIAS_S : EXP_BIAS_N)
               + EXP_W'(signed'(w_hi3[31:20]));
        if (w_hi2b > HI_THRESH) begin
            w_hi2b = w_hi2b - HI_HALF;
            n_e3   = n_e3 + 13'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e3 <= n_e3;
        r_m3 <= {w_hi2b, r_u2[31:0]};
    end

    // exponent to binary64; magnitude fits in 12 bits
    always_comb begin
        w_mag = r_e3[EXP_W-1] ? EXP_W'(-r_e3) : EXP_W'(r_e3);
        w_p4  = f_top12(w_mag[11:0]);
        if (r_e3 == '0) begin
            n_d4 = '0;
        end else begin
            n_d4 = {r_e3[EXP_W-1], 11'd1023 + 11'(w_p4),
                    52'({40'd0, w_mag[11:0]} << (6'(FRAC_W) - 6'(w_p4)))};
        end
    end

    always_ff @(posedge i_clk) begin
        r_e4 <= r_e3;
        r_d4 <= n_d4;
        r_m4 <= r_m3;
    end

    assign o_strobe               = r_v4;
    assign o_exponent_int         = r_e4;
    assign o_exponent_double_bits = r_d4;
    assign o_mantissa_bits        = r_m4;

`ifndef SYNTHESIS
    a_valid_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |=> r_v3) else $error("stage valid lost");
    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_e4 >= -13'sd3070) && (r_e4 <= 13'sd1025))
        else $error("exponent out of range");
    a_zero_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && (r_e4 == '0) |-> (r_d4 == '0)) else $error("zero exponent bits");
    a_sign_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_d4[63] == r_e4[EXP_W-1])) else $error("exponent sign mismatch");
`endif
endmodule
`default_nettype wire

// ===== bench/double_exponent_mantissa_split_tb.sv =====
// Testbench for the binary64 exponent/mantissa split block.
// Drives operands, predicts exponent and mantissa per item, checks each strobed result.
// Depends on dems_pkg and double_exponent_mantissa_split.
module double_exponent_mantissa_split_tb;
    import dems_pkg::*;

    typedef struct packed {
        logic signed [EXP_W-1:0] exp_int;
        logic [VAL_W-1:0]        exp_dbl;
        logic [VAL_W-1:0]        mant;
    } t_split;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic [VAL_W-1:0]  i_value_bits = '0;
    wire               busy;
    wire               o_strobe;
    wire signed [EXP_W-1:0] o_exponent_int;
    wire [VAL_W-1:0]   o_exponent_double_bits;
    wire [VAL_W-1:0]   o_mantissa_bits;

    t_split split_q[$];
    int     n_errors = 0;
    int     n_results = 0;
    int     n_cycles = 0;
    bit     gaps_on = 1'b1;

    double_exponent_mantissa_split i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .start                  (start),
        .busy                   (busy),
        .i_value_bits           (i_value_bits),
        .o_strobe               (o_strobe),
        .o_exponent_int         (o_exponent_int),
        .o_exponent_double_bits (o_exponent_double_bits),
        .o_mantissa_bits        (o_mantissa_bits)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > 200000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int msb_pos(input logic [63:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) p = i;
        return p;
    endfunction

    function automatic logic [63:0] int_as_double(input int e);
        logic [63:0] mag;
        logic [63:0] r;
        int          p;
        if (e == 0) return '0;
        mag = (e < 0) ? 64'(-e) : 64'(e);
        p = msb_pos(mag);
        r = '0;
        r[63] = (e < 0);
        r[62:52] = 11'(1023 + p);
        r[51:0] = 52'(mag << (52 - p));
        return r;
    endfunction

    function automatic t_split predict_split(input logic [63:0] v);
        logic [63:0] u;
        logic [31:0] hi;
        logic [31:0] hi2;
        logic [51:0] frac;
        int          e;
        int          p;
        t_split      r;
        u = v;
        hi = u[63:32];
        e = -1023;
        if (hi < HI_SUBN) begin
            // exact normalising shift standing for the scale by 2^54
            frac = u[51:0];
            if (frac != '0) begin
                p = msb_pos(64'(frac));
                u = '0;
                u[62:52] = 11'(p + 3);
                u[51:0] = 52'(64'(frac) << (52 - p));
            end
            e -= 54;
            hi = u[63:32];
        end
        e += int'($signed(hi[31:20]));
        hi2 = (hi & HI_KEEP) | HI_ONE;
        if (hi2 > HI_THRESH) begin
            hi2 -= HI_HALF;
            e += 1;
        end
        r.exp_int = EXP_W'(e);
        r.exp_dbl = int_as_double(e);
        r.mant = {hi2, u[31:0]};
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_split want;
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (split_q.size() == 0) begin
                $error("result with no item outstanding");
                n_errors++;
            end else begin
                want = split_q.pop_front();
                if (o_exponent_int !== want.exp_int) begin
                    $error("exponent_int: expected %0d, got %0d",
                           want.exp_int, o_exponent_int);
                    n_errors++;
                end
                if (o_exponent_double_bits !== want.exp_dbl) begin
                    $error("exponent_double_bits: expected %h, got %h",
                           want.exp_dbl, o_exponent_double_bits);
                    n_errors++;
                end
                if (o_mantissa_bits !== want.mant) begin
                    $error("mantissa_bits: expected %h, got %h",
                           want.mant, o_mantissa_bits);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_item(input logic [63:0] v);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_value_bits <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        split_q.push_back(predict_split(v));
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_extremes();
        logic [63:0] list[$];
        list = '{64'h0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                 64'h000f_ffff_ffff_ffff, 64'h0008_0000_0000_0000,
                 64'h0000_0001_0000_0000, 64'h800f_ffff_ffff_ffff,
                 64'h8000_0000_0000_0001, 64'h0010_0000_0000_0000,
                 64'h3ff0_0000_0000_0000, 64'h3ff6_a09e_ffff_ffff,
                 64'h3ff6_a09f_0000_0000, 64'h3fe6_a09e_6670_0000,
                 64'h7fef_ffff_ffff_ffff, 64'h7ff0_0000_0000_0000,
                 64'h7ff8_0000_0000_0001, 64'hfff0_0000_0000_0000,
                 64'hffff_ffff_ffff_ffff, 64'hbff0_0000_0000_0000,
                 64'h4000_0000_0000_0000, 64'h000f_ffff_0000_0000};
        foreach (list[i]) send_item(list[i]);
        go_idle();
    endtask

    task automatic test_random(input int count);
        logic [63:0] v;
        for (int i = 0; i < count; i++) begin
            v = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: v[62:52] = '0;                          // subnormal or zero
                1: v[62:52] = 11'h7ff;                     // inf / nan
                2: v[62:52] = 11'(1023 + $urandom_range(0, 1) - 1);
                3: v[51:32] = 20'h6a09e + 20'($urandom_range(0, 2)) - 20'd1;
                default: ;
            endcase
            send_item(v);
        end
        go_idle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random(1200);
        gaps_on = 1'b0;             // back-to-back items at the end
        test_random(300);
        while (split_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Covered %0d results: zero, subnormals, negatives, inf/nan,", n_results);
        $display("threshold neighbours and random operands, with and without gaps.");
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
